/* hdl/spi_ssd_pkg.sv */
// Shared types, constants and register codes for the SPI sample stream decoder.
`timescale 1ns / 1ps

package spi_ssd_pkg;

    localparam int unsigned CHANNEL_COUNT_DEFAULT = 8;
    localparam int unsigned CHAN_W                = 8;
    localparam int unsigned TIME_W                = 64;
    localparam int unsigned LINE_W                = 3;
    localparam int unsigned BYTE_W                = 8;
    localparam int unsigned CFG_INDEX_W           = 3;
    localparam int unsigned CFG_DATA_W            = 3;
    localparam int unsigned IN_TDATA_W            = CHAN_W + TIME_W;
    localparam int unsigned OUT_TDATA_W           = 2 * BYTE_W + TIME_W;

    localparam logic [LINE_W-1:0] CLOCK_LINE_RESET  = 3'd0;
    localparam logic [LINE_W-1:0] SELECT_LINE_RESET = 3'd1;
    localparam logic [LINE_W-1:0] MOSI_LINE_RESET   = 3'd2;
    localparam logic [LINE_W-1:0] MISO_LINE_RESET   = 3'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CLOCK_POLARITY = 3'd0,
        CFG_CLOCK_PHASE    = 3'd1,
        CFG_CLOCK_LINE     = 3'd2,
        CFG_SELECT_LINE    = 3'd3,
        CFG_MOSI_LINE      = 3'd4,
        CFG_MISO_LINE      = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic              clock_polarity;
        logic              clock_phase;
        logic [LINE_W-1:0] clock_line;
        logic [LINE_W-1:0] select_line;
        logic [LINE_W-1:0] mosi_line;
        logic [LINE_W-1:0] miso_line;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] byte_time;
        logic [BYTE_W-1:0] miso_data;
        logic [BYTE_W-1:0] mosi_data;
    } t_result_data;

    typedef struct packed {
        logic         valid;
        t_result_data data;
    } t_result;

endpackage

/* hdl/spi_ssd_cfg.sv */
// Configuration register bank for the SPI sample stream decoder.
`timescale 1ns / 1ps

module spi_ssd_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr,
    input  logic [spi_ssd_pkg::CFG_INDEX_W-1:0] i_index,
    input  logic [spi_ssd_pkg::CFG_DATA_W-1:0]  i_data,
    output spi_ssd_pkg::t_cfg                   o_cfg
);

    spi_ssd_pkg::t_cfg r_cfg;
    spi_ssd_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            case (spi_ssd_pkg::t_cfg_index'(i_index))
                spi_ssd_pkg::CFG_CLOCK_POLARITY: n_cfg.clock_polarity = i_data[0];
                spi_ssd_pkg::CFG_CLOCK_PHASE:    n_cfg.clock_phase    = i_data[0];
                spi_ssd_pkg::CFG_CLOCK_LINE:     n_cfg.clock_line     = i_data;
                spi_ssd_pkg::CFG_SELECT_LINE:    n_cfg.select_line    = i_data;
                spi_ssd_pkg::CFG_MOSI_LINE:      n_cfg.mosi_line      = i_data;
                spi_ssd_pkg::CFG_MISO_LINE:      n_cfg.miso_line      = i_data;
                default:                         n_cfg                = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clock_polarity <= 1'b0;
            r_cfg.clock_phase    <= 1'b0;
            r_cfg.clock_line     <= spi_ssd_pkg::CLOCK_LINE_RESET;
            r_cfg.select_line    <= spi_ssd_pkg::SELECT_LINE_RESET;
            r_cfg.mosi_line      <= spi_ssd_pkg::MOSI_LINE_RESET;
            r_cfg.miso_line      <= spi_ssd_pkg::MISO_LINE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/spi_ssd_core.sv */
// Frame and bit tracking state with the per-sample decode logic.
`timescale 1ns / 1ps

module spi_ssd_core #(
    parameter int unsigned P_CHANNEL_COUNT = spi_ssd_pkg::CHANNEL_COUNT_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_beat,
    input  logic [spi_ssd_pkg::CHAN_W-1:0]      i_channels,
    input  logic [spi_ssd_pkg::TIME_W-1:0]      i_timestamp,
    input  spi_ssd_pkg::t_cfg                   i_cfg,
    output spi_ssd_pkg::t_result                o_res
);

    logic                           r_have_prev, n_have_prev;
    logic                           r_prev_clk,  n_prev_clk;
    logic                           r_active,    n_active;
    logic [2:0]                     r_bit_cnt,   n_bit_cnt;
    logic [spi_ssd_pkg::BYTE_W-1:0] r_mosi,      n_mosi;
    logic [spi_ssd_pkg::BYTE_W-1:0] r_miso,      n_miso;

    logic lines_ok;
    logic clk_lvl;
    logic shift_now;

    assign lines_ok = (32'(i_cfg.clock_line)  < P_CHANNEL_COUNT) &&
                      (32'(i_cfg.select_line) < P_CHANNEL_COUNT) &&
                      (32'(i_cfg.mosi_line)   < P_CHANNEL_COUNT) &&
                      (32'(i_cfg.miso_line)   < P_CHANNEL_COUNT);
    assign clk_lvl  = i_channels[i_cfg.clock_line];
    assign shift_now = (i_cfg.clock_polarity == i_cfg.clock_phase) ?
                       (!r_prev_clk && clk_lvl) : (r_prev_clk && !clk_lvl);

    always_comb begin
        n_have_prev = r_have_prev;
        n_prev_clk  = r_prev_clk;
        n_active    = r_active;
        n_bit_cnt   = r_bit_cnt;
        n_mosi      = r_mosi;
        n_miso      = r_miso;
        o_res.valid          = 1'b0;
        o_res.data.mosi_data = '0;
        o_res.data.miso_data = '0;
        o_res.data.byte_time = i_timestamp;
        if (i_beat && lines_ok) begin
            n_prev_clk = clk_lvl;
            if (!r_have_prev) begin
                n_have_prev = 1'b1;
            end else if (i_channels[i_cfg.select_line]) begin
                n_active  = 1'b0;
                n_bit_cnt = 3'd0;
            end else begin
                if (!r_active) begin
                    n_active  = 1'b1;
                    n_bit_cnt = 3'd0;
                    n_mosi    = '0;
                    n_miso    = '0;
                end
                if (shift_now) begin
                    n_mosi    = {n_mosi[spi_ssd_pkg::BYTE_W-2:0], i_channels[i_cfg.mosi_line]};
                    n_miso    = {n_miso[spi_ssd_pkg::BYTE_W-2:0], i_channels[i_cfg.miso_line]};
                    n_bit_cnt = n_bit_cnt + 3'd1;
                    if (n_bit_cnt == 3'd0) begin
                        o_res.valid          = 1'b1;
                        o_res.data.mosi_data = n_mosi;
                        o_res.data.miso_data = n_miso;
                        n_mosi = '0;
                        n_miso = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev_clk  <= 1'b0;
            r_active    <= 1'b0;
            r_bit_cnt   <= 3'd0;
            r_mosi      <= '0;
            r_miso      <= '0;
        end else begin
            r_have_prev <= n_have_prev;
            r_prev_clk  <= n_prev_clk;
            r_active    <= n_active;
            r_bit_cnt   <= n_bit_cnt;
            r_mosi      <= n_mosi;
            r_miso      <= n_miso;
        end
    end

endmodule

/* hdl/spi_ssd_obuf.sv */
// Two-entry result register with skid slot for the output stream.
`timescale 1ns / 1ps

module spi_ssd_obuf (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  spi_ssd_pkg::t_result      i_res,
    input  logic                      i_ready,
    output logic                      o_valid,
    output spi_ssd_pkg::t_result_data o_data,
    output logic                      o_full
);

    logic                      r_head_v, n_head_v;
    logic                      r_tail_v, n_tail_v;
    spi_ssd_pkg::t_result_data r_head,   n_head;
    spi_ssd_pkg::t_result_data r_tail,   n_tail;

    always_comb begin
        n_head_v = r_head_v;
        n_tail_v = r_tail_v;
        n_head   = r_head;
        n_tail   = r_tail;
        if (r_head_v && i_ready) begin
            n_head_v = r_tail_v;
            n_head   = r_tail;
            n_tail_v = 1'b0;
        end
        if (i_res.valid) begin
            if (!n_head_v) begin
                n_head_v = 1'b1;
                n_head   = i_res.data;
            end else begin
                n_tail_v = 1'b1;
                n_tail   = i_res.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
            r_tail_v <= 1'b0;
        end else begin
            r_head_v <= n_head_v;
            r_tail_v <= n_tail_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
    end

    assign o_valid = r_head_v;
    assign o_data  = r_head;
    assign o_full  = r_tail_v;

endmodule

/* hdl/spi_sample_stream_decoder.sv */
// Top level of the SPI sample stream decoder.
//
// Each input beat carries one logic-analyzer sample: the channel word and
// its timestamp. The decoder tracks the configured clock, chip-select and
// data lines and emits one output beat with the MOSI byte, the MISO byte
// and the timestamp of the sample that completed the eighth bit.
// Configuration registers are written through the cfg channel, which is
// always ready; writes are meant to happen while the stream is idle.
// A sample is decoded in the cycle it is accepted, and its result is
// presented on the output from a result register. The block accepts one
// sample per cycle; a second result register takes one more byte while
// the receiver stalls, so the input ready only drops once both result
// registers are full, and rises again on the next take. Reset clears the
// register bank to its defaults, the frame state and the result valid
// bits; the first sample after reset only records the clock.
`timescale 1ns / 1ps

module spi_sample_stream_decoder #(
    parameter int unsigned P_CHANNEL_COUNT = spi_ssd_pkg::CHANNEL_COUNT_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // channels [7:0], timestamp [71:8]
    input  logic [spi_ssd_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // mosi_data [7:0], miso_data [15:8], byte_time [79:16]
    output logic [spi_ssd_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [spi_ssd_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [spi_ssd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    spi_ssd_pkg::t_cfg         w_cfg;
    spi_ssd_pkg::t_result      w_res;
    spi_ssd_pkg::t_result_data w_out;
    logic                      w_full;
    logic                      w_in_beat;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !w_full;
    assign w_in_beat       = i_s_axis_tvalid && o_s_axis_tready;

    spi_ssd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    spi_ssd_core #(
        .P_CHANNEL_COUNT (P_CHANNEL_COUNT)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (w_in_beat),
        .i_channels  (i_s_axis_tdata[spi_ssd_pkg::CHAN_W-1:0]),
        .i_timestamp (i_s_axis_tdata[spi_ssd_pkg::IN_TDATA_W-1:spi_ssd_pkg::CHAN_W]),
        .i_cfg       (w_cfg),
        .o_res       (w_res)
    );

    spi_ssd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (w_res),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (w_out),
        .o_full  (w_full)
    );

    assign o_m_axis_tdata = w_out;

`ifndef SYNTHESIS
    a_res_from_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> w_in_beat)
        else $error("result produced without an accepted sample");

    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled while no result is pending");

    a_res_shows_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |=> o_m_axis_tvalid)
        else $error("decoded byte did not reach the output");
`endif

endmodule

/* bench/tb_spi_sample_stream_decoder.sv */
// Self-checking testbench for the SPI sample stream decoder with handshake stalls.
`timescale 1ns / 1ps

module tb_spi_sample_stream_decoder;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int SAMPLE_TARGET  = 1750;
    localparam int MIN_BYTES      = 60;
    localparam int PHASES         = 8;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam int unsigned CHAN_W      = spi_ssd_pkg::CHAN_W;
    localparam int unsigned TIME_W      = spi_ssd_pkg::TIME_W;
    localparam int unsigned BYTE_W      = spi_ssd_pkg::BYTE_W;
    localparam int unsigned IN_TDATA_W  = spi_ssd_pkg::IN_TDATA_W;
    localparam int unsigned OUT_TDATA_W = spi_ssd_pkg::OUT_TDATA_W;
    localparam int unsigned CFG_INDEX_W = spi_ssd_pkg::CFG_INDEX_W;
    localparam int unsigned CFG_DATA_W  = spi_ssd_pkg::CFG_DATA_W;

    // Register indexes past the end of the bank; writes to them must be ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct {
        logic [CHAN_W-1:0] ch;
        logic [TIME_W-1:0] stamp;
        bit                typed;
        bit                want;
        logic [BYTE_W-1:0] mosi;
        logic [BYTE_W-1:0] miso;
    } t_row;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic [IN_TDATA_W-1:0]  s_data    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [OUT_TDATA_W-1:0] m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    spi_ssd_pkg::t_cfg shadow = '{1'b0, 1'b0, spi_ssd_pkg::CLOCK_LINE_RESET,
                                  spi_ssd_pkg::SELECT_LINE_RESET,
                                  spi_ssd_pkg::MOSI_LINE_RESET,
                                  spi_ssd_pkg::MISO_LINE_RESET};
    bit                seen_first = 1'b0;
    bit                last_clk   = 1'b0;
    bit                in_frame   = 1'b0;
    logic [2:0]        bit_cnt    = '0;
    logic [BYTE_W-1:0] mosi_acc   = '0;
    logic [BYTE_W-1:0] miso_acc   = '0;

    spi_ssd_pkg::t_result_data pending_bytes[$];
    int           bytes_expected = 0;
    int           samples_sent   = 0;
    int           mismatches     = 0;
    int           quiet_cycles   = 0;
    bit           tx_steady      = 1'b0;
    bit           rx_steady      = 1'b0;
    bit           hold_off       = 1'b0;

    // Default wiring: clock bit 0, select bit 1, MOSI bit 2, MISO bit 3.
    t_row script [22] = '{
        '{8'hFF, 64'd0,                  1, 0, 8'h00, 8'h00},
        '{8'h02, 64'd1,                  1, 0, 8'h00, 8'h00},
        '{8'hF5, 64'd2,                  0, 0, 8'h00, 8'h00},
        '{8'hF4, 64'd3,                  0, 0, 8'h00, 8'h00},
        '{8'hF5, 64'd4,                  0, 0, 8'h00, 8'h00},
        '{8'hF4, 64'd5,                  0, 0, 8'h00, 8'h00},
        '{8'hF5, 64'd6,                  0, 0, 8'h00, 8'h00},
        '{8'hF4, 64'd7,                  0, 0, 8'h00, 8'h00},
        '{8'hF5, 64'd8,                  0, 0, 8'h00, 8'h00},
        '{8'hF4, 64'd9,                  0, 0, 8'h00, 8'h00},
        '{8'hF5, 64'd10,                 0, 0, 8'h00, 8'h00},
        '{8'hF4, 64'd11,                 0, 0, 8'h00, 8'h00},
        '{8'hF5, 64'd12,                 0, 0, 8'h00, 8'h00},
        '{8'hF4, 64'd13,                 0, 0, 8'h00, 8'h00},
        '{8'hF5, 64'd14,                 0, 0, 8'h00, 8'h00},
        '{8'hF4, 64'd15,                 0, 0, 8'h00, 8'h00},
        '{8'hF5, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 8'hFF, 8'h00},
        '{8'h08, 64'h8000_0000_0000_0000, 0, 0, 8'h00, 8'h00},
        '{8'h09, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 8'h00, 8'h00},
        '{8'h0B, 64'h5555_AAAA_5555_AAAA, 1, 0, 8'h00, 8'h00},
        '{8'h08, 64'hAAAA_5555_AAAA_5555, 0, 0, 8'h00, 8'h00},
        '{8'h09, 64'h0123_4567_89AB_CDEF, 0, 0, 8'h00, 8'h00}
    };

    spi_ssd_pkg::t_cfg fixed_settings [5] = '{
        '{1'b1, 1'b1, 3'd7, 3'd6, 3'd5, 3'd4},
        '{1'b0, 1'b1, 3'd3, 3'd0, 3'd7, 3'd1},
        '{1'b1, 1'b0, 3'd5, 3'd2, 3'd0, 3'd7},
        '{1'b0, 1'b0, 3'd0, 3'd1, 3'd2, 3'd3},
        '{1'b0, 1'b1, 3'd0, 3'd7, 3'd6, 3'd6}
    };

    spi_sample_stream_decoder uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void decode_sample(input logic [CHAN_W-1:0] ch,
                                          input logic [TIME_W-1:0] stamp,
                                          output bit made,
                                          output spi_ssd_pkg::t_result_data r);
        logic sck;
        logic prev;
        logic take;
        made = 1'b0;
        r = '0;
        sck = ch[shadow.clock_line];
        if (!seen_first) begin
            seen_first = 1'b1;
            last_clk = sck;
            return;
        end
        prev = last_clk;
        last_clk = sck;
        if (ch[shadow.select_line]) begin
            in_frame = 1'b0;
            bit_cnt = '0;
            return;
        end
        if (!in_frame) begin
            in_frame = 1'b1;
            bit_cnt = '0;
            mosi_acc = '0;
            miso_acc = '0;
        end
        if (shadow.clock_polarity == shadow.clock_phase) begin
            take = !prev && sck;
        end else begin
            take = prev && !sck;
        end
        if (!take) begin
            return;
        end
        mosi_acc = {mosi_acc[BYTE_W-2:0], ch[shadow.mosi_line]};
        miso_acc = {miso_acc[BYTE_W-2:0], ch[shadow.miso_line]};
        bit_cnt = bit_cnt + 3'd1;
        if (bit_cnt != 3'd0) begin
            return;
        end
        made = 1'b1;
        r.mosi_data = mosi_acc;
        r.miso_data = miso_acc;
        r.byte_time = stamp;
        mosi_acc = '0;
        miso_acc = '0;
        bytes_expected++;
    endfunction

    function automatic logic [TIME_W-1:0] rand_stamp();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [CHAN_W-1:0] line_word(input bit cs, input bit sck,
                                                    input bit mo, input bit mi);
        logic [CHAN_W-1:0] w;
        w = CHAN_W'($urandom);
        w[shadow.mosi_line] = mo;
        w[shadow.miso_line] = mi;
        w[shadow.select_line] = cs;
        w[shadow.clock_line] = sck;
        return w;
    endfunction

    function automatic spi_ssd_pkg::t_cfg random_setting();
        spi_ssd_pkg::t_cfg c;
        int base;
        int step;
        base = $urandom_range(0, 7);
        step = 2 * $urandom_range(0, 3) + 1;
        c.clock_polarity = 1'($urandom);
        c.clock_phase = 1'($urandom);
        c.clock_line = 3'(base);
        c.select_line = 3'(base + step);
        c.mosi_line = 3'(base + 2 * step);
        c.miso_line = 3'(base + 3 * step);
        return c;
    endfunction

    task automatic offer_sample(input logic [CHAN_W-1:0] ch, input logic [TIME_W-1:0] stamp);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data <= {stamp, ch};
        do @(posedge clk); while (!s_ready);
        samples_sent++;
    endtask

    task automatic put_sample(input logic [CHAN_W-1:0] ch, input logic [TIME_W-1:0] stamp);
        bit made;
        spi_ssd_pkg::t_result_data r;
        offer_sample(ch, stamp);
        decode_sample(ch, stamp, made, r);
        if (made) begin
            pending_bytes.push_back(r);
        end
    endtask

    // Idle with select high, then clock pulses with data held per bit, then a trailing
    // idle-level sample so that trailing-edge modes take their last bit.
    task automatic drive_spi_frame();
        int nbits;
        bit mo;
        bit mi;
        nbits = 8 * $urandom_range(1, 3);
        if ($urandom_range(0, 4) == 0) begin
            nbits = $urandom_range(1, 23);
        end
        mo = 1'($urandom);
        mi = 1'($urandom);
        repeat ($urandom_range(1, 3)) begin
            put_sample(line_word(1'b1, shadow.clock_polarity, mo, mi), rand_stamp());
        end
        for (int b = 0; b < nbits; b++) begin
            mo = 1'($urandom);
            mi = 1'($urandom);
            repeat ($urandom_range(1, 2)) begin
                put_sample(line_word(1'b0, shadow.clock_polarity, mo, mi), rand_stamp());
            end
            repeat ($urandom_range(1, 2)) begin
                put_sample(line_word(1'b0, !shadow.clock_polarity, mo, mi), rand_stamp());
            end
        end
        put_sample(line_word(1'b0, shadow.clock_polarity, mo, mi), rand_stamp());
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            spi_ssd_pkg::CFG_CLOCK_POLARITY: shadow.clock_polarity = val[0];
            spi_ssd_pkg::CFG_CLOCK_PHASE:    shadow.clock_phase = val[0];
            spi_ssd_pkg::CFG_CLOCK_LINE:     shadow.clock_line = val;
            spi_ssd_pkg::CFG_SELECT_LINE:    shadow.select_line = val;
            spi_ssd_pkg::CFG_MOSI_LINE:      shadow.mosi_line = val;
            spi_ssd_pkg::CFG_MISO_LINE:      shadow.miso_line = val;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input spi_ssd_pkg::t_cfg c);
        write_reg(spi_ssd_pkg::CFG_CLOCK_POLARITY, {2'($urandom), c.clock_polarity});
        write_reg(spi_ssd_pkg::CFG_CLOCK_PHASE, {2'($urandom), c.clock_phase});
        write_reg(spi_ssd_pkg::CFG_CLOCK_LINE, c.clock_line);
        write_reg(spi_ssd_pkg::CFG_SELECT_LINE, c.select_line);
        write_reg(spi_ssd_pkg::CFG_MOSI_LINE, c.mosi_line);
        write_reg(spi_ssd_pkg::CFG_MISO_LINE, c.miso_line);
        write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 3'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin : stimulus
        bit made;
        spi_ssd_pkg::t_result_data r;
        int target;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        foreach (script[i]) begin
            offer_sample(script[i].ch, script[i].stamp);
            decode_sample(script[i].ch, script[i].stamp, made, r);
            if (script[i].typed) begin
                if (script[i].want) begin
                    pending_bytes.push_back('{script[i].stamp, script[i].miso, script[i].mosi});
                end
            end else if (made) begin
                pending_bytes.push_back(r);
            end
        end
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                wait_drained();
                apply_setting(phase <= 5 ? fixed_settings[phase - 1] : random_setting());
            end
            target = (phase + 1) * SAMPLE_TARGET / PHASES;
            if (phase == 2) begin
                // The receiver stops taking beats while the sender streams without gaps.
                hold_off = 1'b1;
                tx_steady = 1'b1;
                repeat (4) drive_spi_frame();
            end
            tx_steady = (phase % 3 == 1);
            rx_steady = (phase % 4 == 3);
            while (samples_sent < target) begin
                if ($urandom_range(0, 7) == 0) begin
                    repeat ($urandom_range(4, 12)) put_sample(CHAN_W'($urandom), rand_stamp());
                end else begin
                    drive_spi_frame();
                end
            end
        end
        while (bytes_expected < MIN_BYTES) drive_spi_frame();
        wait_drained();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : receiver
        int stall;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off = 1'b0;
                m_ready <= 1'b1;
            end else if (m_valid && m_ready) begin
                stall = rx_steady ? 0 : $urandom_range(0, 19);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                    m_ready <= 1'b1;
                end
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : result_check
        spi_ssd_pkg::t_result_data got;
        spi_ssd_pkg::t_result_data want;
        if (rst_n && m_valid && m_ready) begin
            got = m_data;
            if (pending_bytes.size() == 0) begin
                $error("result beat with nothing expected: %h", m_data);
                mismatches++;
            end else begin
                want = pending_bytes.pop_front();
                if (got.mosi_data !== want.mosi_data) begin
                    $error("mosi_data expected %h got %h", want.mosi_data, got.mosi_data);
                    mismatches++;
                end
                if (got.miso_data !== want.miso_data) begin
                    $error("miso_data expected %h got %h", want.miso_data, got.miso_data);
                    mismatches++;
                end
                if (got.byte_time !== want.byte_time) begin
                    $error("byte_time expected %h got %h", want.byte_time, got.byte_time);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
